// ===== rtl/core/scfv_pkg.sv =====
package scfv_pkg;

   // Longest frame accepted; longer frames are reported as too long
   localparam int MAX_FRAME = 1024;
   // Position counter saturates at MAX_FRAME, so it must hold that value
   localparam int POS_W     = $clog2(MAX_FRAME + 1);
   localparam int MIN_FRAME = 6;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_HEAD = 2'd0;
   localparam logic [1:0] REG_TAIL = 2'd1;
   localparam logic [1:0] REG_FUNC = 2'd2;

   localparam logic [7:0]  HEAD_RESET = 8'h7E;
   localparam logic [15:0] TAIL_RESET = 16'h0D0A;
   localparam logic [7:0]  FUNC_RESET = 8'h04;

   // Verdict codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_HEAD  = 3'd1;
   localparam logic [2:0] ST_TAIL  = 3'd2;
   localparam logic [2:0] ST_FUNC  = 3'd3;
   localparam logic [2:0] ST_SUM   = 3'd4;
   localparam logic [2:0] ST_SHORT = 3'd5;
   localparam logic [2:0] ST_LONG  = 3'd6;

   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic [7:0]  head_byte;
      logic [15:0] tail_word;
      logic [7:0]  receive_function;
   } scfv_cfg_type;

   // One classified request, as queued from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       first;
      logic       at_len_hi;
      logic       at_len_lo;
      logic       at_func;
      logic       at_serial;
      logic       at_command;
      logic       sum_en;
      logic       short_frame;
      logic       long_frame;
   } scfv_item_type;

endpackage

// ===== rtl/core/scfv_front.sv =====
module scfv_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   q_full,
   output logic                   q_push,
   output scfv_pkg::scfv_item_type q_item
);
   import scfv_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept;

   // Classify the request by its place in the frame
   always_comb begin
      q_item.data        = req_tdata;
      q_item.last        = req_tlast;
      q_item.first       = (pos_ff == POS_W'(0));
      q_item.at_len_hi   = (pos_ff == POS_W'(1));
      q_item.at_len_lo   = (pos_ff == POS_W'(2));
      q_item.at_func     = (pos_ff == POS_W'(3));
      q_item.at_serial   = (pos_ff == POS_W'(4));
      q_item.at_command  = (pos_ff == POS_W'(5));
      q_item.sum_en      = (pos_ff >= POS_W'(MIN_FRAME));
      q_item.short_frame = (pos_ff < POS_W'(MIN_FRAME - 1));
      q_item.long_frame  = (pos_ff >= POS_W'(MAX_FRAME));
   end

   // Advance the saturating position, restart after the last byte
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_tlast) begin
            pos_in = '0;
         end else if (pos_ff < POS_W'(MAX_FRAME)) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

`ifndef ASSERT_OFF
   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> pos_ff == '0)
      else $error("position not restarted after last byte");
`endif

endmodule

// ===== rtl/core/scfv_queue.sv =====
module scfv_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  scfv_pkg::scfv_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output scfv_pkg::scfv_item_type pop_item
);
   import scfv_pkg::*;

   scfv_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill level beyond depth");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      do_pop && !push |=> count_ff == $past(count_ff) - QCNT_W'(1))
      else $error("queue fill level not reduced by pop");
`endif

endmodule

// ===== rtl/core/scfv_back.sv =====
module scfv_back (
   input  logic                       clock,
   input  logic                       reset,
   input  scfv_pkg::scfv_cfg_type      cfg,
   input  logic                       q_valid,
   input  scfv_pkg::scfv_item_type     q_item,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [scfv_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import scfv_pkg::*;

   logic [7:0]  sum_ff;
   logic [7:0]  sum_in;
   logic [7:0]  recent_ff [3];
   logic [7:0]  recent_in [3];
   logic        head_ok_ff;
   logic        head_ok_in;
   logic        func_ok_ff;
   logic        func_ok_in;
   logic [7:0]  serial_ff;
   logic [7:0]  serial_in;
   logic [7:0]  command_ff;
   logic [7:0]  command_in;
   logic [15:0] length_ff;
   logic [15:0] length_in;
   logic [2:0]  status;
   logic        out_free;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   // Take a request unless it ends a frame and the result slot is busy
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = q_valid && (!q_item.last || out_free);

   // Update the frame state for the popped byte
   always_comb begin
      sum_in     = sum_ff;
      head_ok_in = head_ok_ff;
      func_ok_in = func_ok_ff;
      serial_in  = serial_ff;
      command_in = command_ff;
      length_in  = length_ff;
      recent_in  = recent_ff;
      if (q_item.first) begin
         serial_in  = '0;
         command_in = '0;
         length_in  = '0;
         head_ok_in = (q_item.data == cfg.head_byte);
      end
      if (q_item.at_len_hi) begin
         length_in = {q_item.data, 8'h00};
      end
      if (q_item.at_len_lo) begin
         length_in = {length_ff[15:8], q_item.data};
      end
      if (q_item.at_func) begin
         func_ok_in = (q_item.data == cfg.receive_function);
      end
      if (q_item.at_serial) begin
         serial_in = q_item.data;
      end
      if (q_item.at_command) begin
         command_in = q_item.data;
      end
      // Byte three places back joins the checksum
      if (q_item.sum_en) begin
         sum_in = sum_ff + recent_ff[2];
      end
      recent_in[2] = recent_ff[1];
      recent_in[1] = recent_ff[0];
      recent_in[0] = q_item.data;
   end

   // Pick the first failing check
   always_comb begin
      if (q_item.short_frame) begin
         status = ST_SHORT;
      end else if (q_item.long_frame) begin
         status = ST_LONG;
      end else if (!head_ok_ff) begin
         status = ST_HEAD;
      end else if ({recent_ff[0], q_item.data} != cfg.tail_word) begin
         status = ST_TAIL;
      end else if (!func_ok_ff) begin
         status = ST_FUNC;
      end else if (recent_ff[1] != sum_in) begin
         status = ST_SUM;
      end else begin
         status = ST_OK;
      end
   end

   // Load the result slot on a frame end, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (q_pop && q_item.last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, length_in, command_in, serial_in, status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         recent_ff    <= '{default: '0};
         head_ok_ff   <= 1'b0;
         func_ok_ff   <= 1'b0;
         serial_ff    <= '0;
         command_ff   <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            serial_ff  <= serial_in;
            command_ff <= command_in;
            length_ff  <= length_in;
            if (q_item.last) begin
               sum_ff     <= '0;
               recent_ff  <= '{default: '0};
               head_ok_ff <= 1'b0;
               func_ok_ff <= 1'b0;
            end else begin
               sum_ff     <= sum_in;
               recent_ff  <= recent_in;
               head_ok_ff <= head_ok_in;
               func_ok_ff <= func_ok_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_no_result_mid_frame: assert property (@(posedge clock) disable iff (reset)
      q_pop && !q_item.last && rsp_tready |=> !rsp_valid_ff)
      else $error("result raised for a byte inside a frame");
`endif

endmodule

// ===== rtl/core/sum_checked_frame_validator_core.sv =====
// Channel  Direction  Ports                Content
// req      in         req_tdata, req_tlast one frame byte; tlast on the final byte
// rsp      out        rsp_tdata            one verdict per frame
// csr      in/out     csr_p*               head byte, tail word, function code
//
// Takes one byte per cycle while the queue is not full; a byte is queued the
// cycle it is accepted. The back part pops the last byte from the queue head
// and, at the same edge, loads the verdict into the result register that drives rsp.
// A verdict waiting on rsp holds the next last byte at the queue head; the
// four-entry queue keeps taking bytes until it fills, then req_tready drops.
// Synchronous reset clears frame state and restores register defaults.
module sum_checked_frame_validator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // last_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] status, [10:3] serial_number, [18:11] command_byte,
   // [34:19] declared_length, [39:35] zero
   output logic [scfv_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scfv_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [scfv_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [scfv_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import scfv_pkg::*;

   scfv_cfg_type  cfg_ff;
   scfv_cfg_type  cfg_in;
   logic          csr_wr;
   logic [1:0]    reg_idx;
   logic          q_full;
   logic          q_push;
   scfv_item_type push_item;
   logic          q_pop;
   logic          q_valid;
   scfv_item_type pop_item;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_HEAD: cfg_in.head_byte        = csr_pwdata[7:0];
            REG_TAIL: cfg_in.tail_word        = csr_pwdata[15:0];
            REG_FUNC: cfg_in.receive_function = csr_pwdata[7:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_HEAD: csr_prdata = {24'd0, cfg_ff.head_byte};
         REG_TAIL: csr_prdata = {16'd0, cfg_ff.tail_word};
         REG_FUNC: csr_prdata = {24'd0, cfg_ff.receive_function};
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte        <= HEAD_RESET;
         cfg_ff.tail_word        <= TAIL_RESET;
         cfg_ff.receive_function <= FUNC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scfv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   scfv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (pop_item)
   );

   scfv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
